FILE: rtl/core/nalc_pkg.sv
package nalc_pkg;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_ENABLE    = 2'd1;
  localparam logic [1:0] REG_SEG_LEN   = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [15:0] SEG_LEN_RESET = 16'd512;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one classified input item: one or two results, the final one maybe a terminator
  typedef struct packed {
    logic       two;
    logic       term;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

  typedef struct packed {
    logic        direction;
    logic        enable;
    logic [15:0] seg_len;
  } cfg_t;

endpackage

FILE: rtl/core/nalc_front.sv
module nalc_front import nalc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic held_cr;
  logic held_cr_next;
  logic emit;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && emit;

  always_comb begin
    held_cr_next = held_cr;
    emit         = 1'b1;
    q_cmd        = '{two: 1'b0, term: 1'b0, b0: in_byte, b1: CHAR_NUL};
    if (in_end) begin
      // flush a held CR ahead of the terminator
      q_cmd.term   = 1'b1;
      held_cr_next = 1'b0;
      if (held_cr) begin
        q_cmd.two = 1'b1;
        q_cmd.b0  = CHAR_CR;
      end else begin
        q_cmd.b0 = CHAR_NUL;
      end
    end else if (!cfg.enable) begin
      q_cmd.b0 = in_byte;
    end else if (cfg.direction == DIR_ENCODE) begin
      if (in_byte == CHAR_LF) begin
        q_cmd.two = 1'b1;
        q_cmd.b0  = CHAR_CR;
        q_cmd.b1  = CHAR_LF;
      end else if (in_byte == CHAR_CR) begin
        q_cmd.two = 1'b1;
        q_cmd.b0  = CHAR_CR;
        q_cmd.b1  = CHAR_NUL;
      end
    end else if (held_cr) begin
      if (in_byte == CHAR_LF) begin
        q_cmd.b0     = CHAR_LF;
        held_cr_next = 1'b0;
      end else if (in_byte == CHAR_NUL) begin
        q_cmd.b0     = CHAR_CR;
        held_cr_next = 1'b0;
      end else if (in_byte == CHAR_CR) begin
        q_cmd.b0 = CHAR_CR;
      end else begin
        q_cmd.two    = 1'b1;
        q_cmd.b0     = CHAR_CR;
        q_cmd.b1     = in_byte;
        held_cr_next = 1'b0;
      end
    end else if (in_byte == CHAR_CR) begin
      // hold until the next byte decides
      held_cr_next = 1'b1;
      emit         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cr <= 1'b0;
    end else if (accept) begin
      held_cr <= held_cr_next;
    end
  end

endmodule

FILE: rtl/core/nalc_queue.sv
module nalc_queue import nalc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QAW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push && !full && !do_pop |=> count == $past(count) + (QAW+1)'(1))
    else $error("queue push not counted");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !do_pop)
    else $error("queue popped while empty");

endmodule

FILE: rtl/core/nalc_back.sv
module nalc_back import nalc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_segment_end,
  output logic       out_last
);

  cmd_t        cur;
  logic        cur_valid;
  logic        phase;
  logic [15:0] segment_fill;
  logic [15:0] segment_fill_next;
  logic [15:0] fill_inc;
  logic        adv;
  logic        is_last;
  logic        done;
  logic        res_byte_valid;
  logic        res_segment_end;
  logic [7:0]  res_byte;

  assign adv     = cur_valid && (!out_valid || out_ready);
  assign is_last = phase || !cur.two;
  assign done    = adv && is_last;
  assign q_pop   = q_valid && (!cur_valid || done);

  always_comb begin
    res_byte_valid    = !(cur.term && is_last);
    res_byte          = res_byte_valid ? (phase ? cur.b1 : cur.b0) : CHAR_NUL;
    fill_inc          = segment_fill + 16'd1;
    res_segment_end   = !res_byte_valid || (fill_inc >= cfg.seg_len);
    segment_fill_next = res_segment_end ? 16'd0 : fill_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (adv) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_fill <= 16'd0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      segment_fill <= segment_fill_next;
      out_valid    <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word holds while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte        <= res_byte;
      out_byte_valid  <= res_byte_valid;
      out_segment_end <= res_segment_end;
      out_last        <= is_last;
    end
  end

  a_term_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte_valid |-> out_segment_end && out_last && out_byte == CHAR_NUL)
    else $error("terminator without segment end or last");

  a_term_clears_fill: assert property (@(posedge clk) disable iff (rst)
    adv && !res_byte_valid |=> segment_fill == 16'd0)
    else $error("fill not cleared after terminator");

  a_phase_two_only: assert property (@(posedge clk) disable iff (rst)
    cur_valid && phase |-> cur.two)
    else $error("second result on a single-result item");

endmodule

FILE: rtl/core/netascii_line_end_codec.sv
// Channel  Dir  Payload                                    Accepted when
// s_axis   in   tdata[7:0] data_byte, tlast end_mark       s_tvalid && s_tready
// m_axis   out  tdata[7:0] out_byte, tlast segment_end,    m_tvalid && m_tready
//               tuser[0] byte_valid, tuser[1] last
// apb      in   direction @0, netascii_enable @4,          psel && penable && pwrite
//               seg_len @8
//
// The front classifies one input word per cycle while the 4-entry queue has room.
// The back drains the queue, one word per cycle while m_tready holds: single-result
// items give one word; expanded items and a flushed CR before the terminator give two.
// A CR held while decoding yields no word. Reset (rst, synchronous) clears the
// held CR, segment count, queue and output valid; the registers take their
// reset values. A stalled output keeps its word while the front keeps filling the queue.
module netascii_line_end_codec import nalc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_mark
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // segment_end
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       cfg_write;
  logic [1:0] reg_index;
  logic       q_full;
  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_pop;
  logic       q_head_valid;
  cmd_t       q_head_cmd;
  logic       res_byte_valid;
  logic       res_last;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= DIR_ENCODE;
      cfg.enable    <= 1'b1;
      cfg.seg_len   <= SEG_LEN_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_DIRECTION: cfg.direction <= pwdata[0];
        REG_ENABLE:    cfg.enable    <= pwdata[0];
        REG_SEG_LEN:   cfg.seg_len   <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DIRECTION: prdata = {31'd0, cfg.direction};
      REG_ENABLE:    prdata = {31'd0, cfg.enable};
      REG_SEG_LEN:   prdata = {16'd0, cfg.seg_len};
      default:       prdata = 32'd0;
    endcase
  end

  nalc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  nalc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  nalc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_head_valid),
    .q_cmd           (q_head_cmd),
    .q_pop           (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte        (m_tdata),
    .out_byte_valid  (res_byte_valid),
    .out_segment_end (m_tlast),
    .out_last        (res_last)
  );

  assign m_tuser = {res_last, res_byte_valid};

endmodule
